// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL. Each macro samples on the rising edge
// of clk and is disabled while rst_n is low, so a module that uses them must
// have ports or signals of exactly those names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/swrl_pkg.sv =====
package swrl_pkg;

    localparam int TIME_W    = 48;
    localparam int TAG_W     = 32;
    localparam int OPND_W    = 32;
    localparam int MAXORD_W  = 7;
    localparam int WIN_W     = 33;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD     = 2'd0,
        CFG_MAX_ORDERS = 2'd1,
        CFG_MAX_VOLUME = 2'd2
    } cfg_idx_t;

    // Input action codes.
    localparam logic ACT_CHECK    = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // Operations the sequencer issues to a log.
    typedef enum logic [2:0] {
        LOG_NOP     = 3'd0,
        LOG_RD_OLD  = 3'd1,
        LOG_RD_NEW  = 3'd2,
        LOG_POP_OLD = 3'd3,
        LOG_POP_NEW = 3'd4,
        LOG_PUSH    = 3'd5
    } log_op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } log_stat_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [TAG_W-1:0]  tag;
    } count_entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [OPND_W-1:0] amount;
        logic [TAG_W-1:0]  tag;
    } vol_entry_t;

endpackage

// ===== rtl/core/swrl_log.sv =====
`include "assert_macros.svh"

// Circular log held in a memory with one write and one registered read.
module swrl_log
    import swrl_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 80
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  log_op_t                      op,
    input  logic [DATA_W-1:0]            wdata,
    output logic [DATA_W-1:0]            rdata,
    output logic [$clog2(DEPTH+1)-1:0]   size,
    output log_stat_t                    stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(2 * DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [SW-1:0]     size_reg;
    logic [SW-1:0]     size_next;
    logic [PW-1:0]     tail_sum;
    logic [PW-1:0]     tail_wrap;
    logic [PW-1:0]     newest_sum;
    logic [PW-1:0]     newest_wrap;
    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     rd_addr;

    // The head plus the size stays below twice the depth, so one
    // compare and subtract brings a slot back into range.
    assign tail_sum    = PW'(head_reg) + PW'(size_reg);
    assign tail_wrap   = (tail_sum >= DEPTH_P) ? tail_sum - DEPTH_P : tail_sum;
    assign newest_sum  = tail_sum - PW'(1);
    assign newest_wrap = (newest_sum >= DEPTH_P) ? newest_sum - DEPTH_P : newest_sum;
    assign head_inc    = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign rd_addr     = (op == LOG_RD_NEW) ? newest_wrap[AW-1:0] : head_reg;

    assign stat.empty = (size_reg == '0);
    assign stat.full  = (size_reg == SW'(DEPTH));
    assign size       = size_reg;
    assign rdata      = rdata_reg;

    always_comb
    begin
        head_next = head_reg;
        size_next = size_reg;
        unique case (op)
            LOG_POP_OLD:
            begin
                head_next = head_inc;
                size_next = size_reg - SW'(1);
            end
            LOG_POP_NEW: size_next = size_reg - SW'(1);
            LOG_PUSH:    size_next = size_reg + SW'(1);
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            size_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            size_reg <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == LOG_PUSH)
        begin
            mem[tail_wrap[AW-1:0]] <= wdata;
        end
        if (op == LOG_RD_OLD || op == LOG_RD_NEW)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    `ASSERT_ALWAYS(a_size_bound, size_reg <= SW'(DEPTH), "log size exceeds its depth")
    `ASSERT_IMPLIES(a_pop_nonempty, op == LOG_POP_OLD || op == LOG_POP_NEW, !stat.empty, "pop from an empty log")
    `ASSERT_IMPLIES(a_push_not_full, op == LOG_PUSH, !stat.full, "push into a full log")

endmodule

// ===== rtl/core/swrl_addcmp.sv =====
// Shared add and compare: tells whether addend_a + addend_b exceeds bound,
// with the sum carried one bit wider so it never wraps.
module swrl_addcmp
    import swrl_pkg::*;
(
    input  logic [TIME_W-1:0] addend_a,
    input  logic [OPND_W-1:0] addend_b,
    input  logic [TIME_W-1:0] bound,
    output logic              above
);

    logic [TIME_W:0] sum;

    assign sum   = {1'b0, addend_a} + (TIME_W + 1)'(addend_b);
    assign above = (sum > {1'b0, bound});

endmodule

// ===== rtl/core/sliding_window_order_rate_limiter.sv =====
// Sliding-window order rate limiter. Each input beat is either a check of a
// new order or the completion report of an earlier one, and each gives exactly
// one result beat carrying verdict (1 = rejected by a limit). The block holds
// two circular logs in memories, one for the order-count limit and one for the
// volume limit, and a single adder-comparator that a small sequencer reuses
// for every expiry test and for the volume test. A check walks each active log
// from its oldest entry and drops every entry whose timestamp plus
// window_period_ms is not above now_ms; the sum is formed one bit wider, so
// nothing expires early near the top of the time range. Each entry costs one
// memory read and one compare. A failed completion reads the newest entry of
// each log that holds entries and removes it when its tag matches, and a
// check with limiting disabled or a plain completion goes straight to the
// result. The input side is stalled while an item is at work, and the next
// item is taken as soon as the sequencer returns to idle, even while the
// previous result still sits in the output register. An order that fails the
// volume limit keeps its count-log record. Configuration is written through a
// port that is always ready, and should only be written while the block is
// idle; a write to an index beyond the register list is ignored.
`include "assert_macros.svh"

module sliding_window_order_rate_limiter
    import swrl_pkg::*;
#(
    parameter int COUNT_LOG_DEPTH  = 64,
    parameter int VOLUME_LOG_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [TIME_W-1:0]    now_ms,
    input  logic [TAG_W-1:0]     order_tag,
    input  logic [OPND_W-1:0]    order_volume,
    input  logic                 send_failed,
    // Result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 verdict,
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OPND_W-1:0]    cfg_data
);

    localparam int CSW = $clog2(COUNT_LOG_DEPTH + 1);
    localparam int VSW = $clog2(VOLUME_LOG_DEPTH + 1);
    localparam int ORD_CMP_W = (CSW > MAXORD_W) ? CSW : MAXORD_W;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_C_RD    = 12'b0000_0000_0010,
        ST_C_CMP   = 12'b0000_0000_0100,
        ST_C_TEST  = 12'b0000_0000_1000,
        ST_V_RD    = 12'b0000_0001_0000,
        ST_V_CMP   = 12'b0000_0010_0000,
        ST_V_TEST  = 12'b0000_0100_0000,
        ST_RB_VRD  = 12'b0000_1000_0000,
        ST_RB_VCHK = 12'b0001_0000_0000,
        ST_RB_CRD  = 12'b0010_0000_0000,
        ST_RB_CCHK = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t               state_reg;
    state_t               state_next;

    // Configuration registers.
    logic [OPND_W-1:0]    period_reg;
    logic [MAXORD_W-1:0]  max_orders_reg;
    logic [OPND_W-1:0]    max_volume_reg;

    // Captured item.
    logic [TIME_W-1:0]    now_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [OPND_W-1:0]    amount_reg;

    logic                 verdict_reg;
    logic                 verdict_next;
    logic [WIN_W-1:0]     win_reg;
    logic [WIN_W-1:0]     win_next;
    logic                 out_valid_reg;
    logic                 out_verdict_reg;
    logic                 out_load;
    logic                 in_accept;

    // Log interfaces.
    log_op_t              cnt_op;
    log_op_t              vol_op;
    count_entry_t         cnt_wdata;
    count_entry_t         cnt_rdata;
    vol_entry_t           vol_wdata;
    vol_entry_t           vol_rdata;
    logic [CSW-1:0]       cnt_size;
    logic [VSW-1:0]       vol_size;
    log_stat_t            cnt_stat;
    log_stat_t            vol_stat;

    // Shared adder-comparator operands.
    logic [TIME_W-1:0]    cmp_a;
    logic [OPND_W-1:0]    cmp_b;
    logic [TIME_W-1:0]    cmp_c;
    logic                 cmp_above;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign verdict   = out_verdict_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign cnt_wdata = '{stamp: now_reg, tag: tag_reg};
    assign vol_wdata = '{stamp: now_reg, amount: amount_reg, tag: tag_reg};

    swrl_log #(
        .DEPTH  (COUNT_LOG_DEPTH),
        .DATA_W ($bits(count_entry_t))
    ) u_count_log (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (cnt_op),
        .wdata (cnt_wdata),
        .rdata (cnt_rdata),
        .size  (cnt_size),
        .stat  (cnt_stat)
    );

    swrl_log #(
        .DEPTH  (VOLUME_LOG_DEPTH),
        .DATA_W ($bits(vol_entry_t))
    ) u_volume_log (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (vol_op),
        .wdata (vol_wdata),
        .rdata (vol_rdata),
        .size  (vol_size),
        .stat  (vol_stat)
    );

    swrl_addcmp u_addcmp (
        .addend_a (cmp_a),
        .addend_b (cmp_b),
        .bound    (cmp_c),
        .above    (cmp_above)
    );

    // Sequencer. Expiry states read the oldest entry in one cycle and test
    // it in the next; rollback states read the newest entry the same way.
    always_comb
    begin
        state_next   = state_reg;
        verdict_next = verdict_reg;
        win_next     = win_reg;
        cnt_op       = LOG_NOP;
        vol_op       = LOG_NOP;
        cmp_a        = '0;
        cmp_b        = period_reg;
        cmp_c        = now_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    verdict_next = 1'b0;
                    if (action == ACT_COMPLETE)
                    begin
                        state_next = send_failed ? ST_RB_VRD : ST_DONE;
                    end
                    else if (period_reg != '0 &&
                             (max_orders_reg != '0 || max_volume_reg != '0))
                    begin
                        state_next = (max_orders_reg != '0) ? ST_C_RD : ST_V_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_C_RD:
            begin
                if (cnt_stat.empty)
                begin
                    state_next = ST_C_TEST;
                end
                else
                begin
                    cnt_op     = LOG_RD_OLD;
                    state_next = ST_C_CMP;
                end
            end
            ST_C_CMP:
            begin
                cmp_a = cnt_rdata.stamp;
                if (!cmp_above)
                begin
                    cnt_op     = LOG_POP_OLD;
                    state_next = ST_C_RD;
                end
                else
                begin
                    state_next = ST_C_TEST;
                end
            end
            ST_C_TEST:
            begin
                if (ORD_CMP_W'(cnt_size) >= ORD_CMP_W'(max_orders_reg) || cnt_stat.full)
                begin
                    verdict_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cnt_op     = LOG_PUSH;
                    state_next = (max_volume_reg != '0) ? ST_V_RD : ST_DONE;
                end
            end
            ST_V_RD:
            begin
                if (vol_stat.empty)
                begin
                    state_next = ST_V_TEST;
                end
                else
                begin
                    vol_op     = LOG_RD_OLD;
                    state_next = ST_V_CMP;
                end
            end
            ST_V_CMP:
            begin
                cmp_a = vol_rdata.stamp;
                if (!cmp_above)
                begin
                    vol_op     = LOG_POP_OLD;
                    win_next   = win_reg - WIN_W'(vol_rdata.amount);
                    state_next = ST_V_RD;
                end
                else
                begin
                    state_next = ST_V_TEST;
                end
            end
            ST_V_TEST:
            begin
                // The same unit now asks whether the window sum plus this
                // order's volume goes above the volume limit.
                cmp_a      = TIME_W'(win_reg);
                cmp_b      = amount_reg;
                cmp_c      = TIME_W'(max_volume_reg);
                state_next = ST_DONE;
                if (cmp_above || vol_stat.full)
                begin
                    verdict_next = 1'b1;
                end
                else
                begin
                    vol_op   = LOG_PUSH;
                    win_next = win_reg + WIN_W'(amount_reg);
                end
            end
            ST_RB_VRD:
            begin
                if (vol_stat.empty)
                begin
                    state_next = ST_RB_CRD;
                end
                else
                begin
                    vol_op     = LOG_RD_NEW;
                    state_next = ST_RB_VCHK;
                end
            end
            ST_RB_VCHK:
            begin
                if (vol_rdata.tag == tag_reg)
                begin
                    vol_op   = LOG_POP_NEW;
                    win_next = win_reg - WIN_W'(vol_rdata.amount);
                end
                state_next = ST_RB_CRD;
            end
            ST_RB_CRD:
            begin
                if (cnt_stat.empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_op     = LOG_RD_NEW;
                    state_next = ST_RB_CCHK;
                end
            end
            ST_RB_CCHK:
            begin
                if (cnt_rdata.tag == tag_reg)
                begin
                    cnt_op = LOG_POP_NEW;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait here only while the output register still holds an
                // untaken result.
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            verdict_reg    <= 1'b0;
            win_reg        <= '0;
            out_valid_reg  <= 1'b0;
            period_reg     <= '0;
            max_orders_reg <= '0;
            max_volume_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
            win_reg     <= win_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PERIOD:     period_reg     <= cfg_data;
                    CFG_MAX_ORDERS: max_orders_reg <= cfg_data[MAXORD_W-1:0];
                    CFG_MAX_VOLUME: max_volume_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg    <= now_ms;
            tag_reg    <= order_tag;
            amount_reg <= order_volume;
        end
        if (out_load)
        begin
            out_verdict_reg <= verdict_reg;
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, in_accept, state_reg != ST_IDLE, "beat not started")
    `ASSERT_NEXT(a_hold_result, out_valid_reg && out_stall, out_valid_reg, "stalled result lost")
    `ASSERT_IMPLIES(a_empty_window_sum, vol_stat.empty, win_reg == '0, "stray window sum")

endmodule
